### sv/i2c_memory_access_master_unit_defines.svh
// ----------------------------------------------------------------------------
// i2c memory access master assertion macros
// shared property forms for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef I2C_MEMORY_ACCESS_MASTER_UNIT_DEFINES_SVH
`define I2C_MEMORY_ACCESS_MASTER_UNIT_DEFINES_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, constants and helpers of the i2c memory access master
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int COUNT_BITS = 12;
  localparam int PAGE_BITS  = 3;

  localparam logic [10:0] PAGE_MASK = (11'(1) << PAGE_BITS) - 11'(1);

  localparam logic [7:0]  DEVICE_CODE_RST = 8'hA0;
  localparam logic [9:0]  ACK_POLLS_RST   = 10'd250;
  localparam logic [15:0] SETTLE_RST      = 16'd10000;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_BIT_LOW, PH_BIT_HIGH, PH_LOAD,
    PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_RS_A, PH_RS_B, PH_RS_C,
    PH_RS_D, PH_RX_LOW, PH_RX_HIGH, PH_RX_SAMPLE, PH_MA_LOW, PH_MA_HIGH,
    PH_MA_END, PH_SP_A, PH_SP_B, PH_SP_C, PH_UL_LOW, PH_UL_HIGH, PH_SETTLE
  } phase_t;

  typedef enum logic [1:0] {
    STG_DEV_W, STG_OFF, STG_DATA, STG_DEV_R
  } stage_t;

  typedef enum logic [1:0] {
    AFT_FINAL, AFT_RESUME, AFT_UNLOCK, AFT_FAIL
  } after_t;

  typedef enum logic [1:0] {
    STAT_OK, STAT_STUCK, STAT_NACK
  } status_t;

  typedef enum logic [1:0] {
    REG_DEVICE_CODE, REG_ACK_POLLS, REG_SETTLE
  } cfg_idx_t;

  typedef struct packed {
    logic        start_req;
    logic        is_read;
    logic [10:0] mem_addr;
    logic [11:0] byte_count;
    logic [7:0]  wr_byte;
    logic        sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       want_byte;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [7:0]  device_code;
    logic [9:0]  ack_timeout_polls;
    logic [15:0] write_settle_ticks;
  } cfg_t;

  function automatic logic [7:0] dev_byte(logic [7:0] code, logic [10:0] addr);
    logic [10:0] pg;
    logic [10:0] ored;
    pg   = (addr >> 8) & PAGE_MASK;
    ored = (pg << 1) & 11'h00F;
    return code | ored[7:0];
  endfunction

endpackage

`default_nettype wire

### sv/i2c_memory_access_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_memory_access_master_unit
// i2c master for random-access memory reads and writes, one bus tick per item
// ----------------------------------------------------------------------------
// path: an accepted tick is held in the input register and moves to the result
//   register once that register is empty or being taken
// throughput: one tick per cycle while the output is not stalled by out_ready
// reset: synchronous, sequencer idle, valid flags cleared, configuration at its default values
`default_nettype none

module i2c_memory_access_master_unit
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t cfg;
  in_t  in_q;
  logic in_q_valid;
  logic move;
  out_t res;

  i2cm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign move     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || move;

  i2cm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (move),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) in_q_valid <= in_valid;
      if (move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_q <= in_data;
    if (move) out_data <= res;
  end

endmodule

`default_nettype wire

### sv/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// configuration register file of the i2c memory access master
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  logic [7:0]  device_code;
  logic [9:0]  ack_timeout_polls;
  logic [15:0] write_settle_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_code        <= DEVICE_CODE_RST;
      ack_timeout_polls  <= ACK_POLLS_RST;
      write_settle_ticks <= SETTLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_DEVICE_CODE: device_code        <= cfg_data[7:0];
        REG_ACK_POLLS:   ack_timeout_polls  <= cfg_data[9:0];
        REG_SETTLE:      write_settle_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.device_code        = device_code;
  assign cfg.ack_timeout_polls  = ack_timeout_polls;
  assign cfg.write_settle_ticks = write_settle_ticks;

endmodule

`default_nettype wire

### sv/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// bus sequencer: one tick per step, state registers and pin/result logic
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_memory_access_master_unit_defines.svh"

module i2cm_seq
  import i2cm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output out_t      res
);

  phase_t                  phase, phase_next;
  stage_t                  stage, stage_next;
  after_t                  after_stop, after_stop_next;
  status_t                 fail_code, fail_code_next;
  logic [7:0]              shift_reg, shift_reg_next;
  logic [3:0]              bit_index, bit_index_next;
  logic [COUNT_BITS-1:0]   bytes_left, bytes_left_next;
  logic [15:0]             wait_ticks, wait_ticks_next;
  logic [9:0]              poll_count, poll_count_next;
  logic [10:0]             latched_addr, latched_addr_next;
  logic                    read_mode, read_mode_next;

  phase_t                  adv_phase;
  stage_t                  adv_stage;
  after_t                  adv_after;
  logic [7:0]              adv_shift;
  logic [3:0]              adv_bit;

  logic [3:0]              bit_inc;
  logic [10:0]             poll_inc;
  logic [7:0]              rx_shift;
  logic                    last_byte;
  logic [COUNT_BITS-1:0]   bytes_dec;

  logic                    scl, sda, rdv, done;
  logic [7:0]              rdb;
  status_t                 stat;

  assign bit_inc   = bit_index + 4'd1;
  assign poll_inc  = {1'b0, poll_count} + 11'd1;
  assign rx_shift  = {shift_reg[6:0], item.sda_in};
  assign last_byte = (bytes_left <= COUNT_BITS'(1));
  assign bytes_dec = bytes_left - COUNT_BITS'(1);

  // continuation after an acknowledged byte, or after the stop that follows an ack timeout past the device byte
  always_comb begin
    adv_phase = phase;
    adv_stage = stage;
    adv_after = after_stop;
    adv_shift = shift_reg;
    adv_bit   = bit_index;
    unique case (stage)
      STG_DEV_W: begin
        adv_shift = latched_addr[7:0];
        adv_stage = STG_OFF;
        adv_bit   = 4'd0;
        adv_phase = PH_BIT_LOW;
      end
      STG_DEV_R: begin
        if (bytes_left != '0) begin
          adv_bit   = 4'd0;
          adv_shift = 8'd0;
          adv_phase = PH_RX_LOW;
        end else begin
          adv_after = AFT_FINAL;
          adv_phase = PH_SP_A;
        end
      end
      default: begin
        if (stage == STG_OFF && read_mode) begin
          adv_phase = PH_RS_A;
        end else if (bytes_left != '0) begin
          adv_stage = STG_DATA;
          adv_phase = PH_LOAD;
        end else begin
          adv_after = AFT_FINAL;
          adv_phase = PH_SP_A;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next        = phase;
    stage_next        = stage;
    after_stop_next   = after_stop;
    fail_code_next    = fail_code;
    shift_reg_next    = shift_reg;
    bit_index_next    = bit_index;
    bytes_left_next   = bytes_left;
    wait_ticks_next   = wait_ticks;
    poll_count_next   = poll_count;
    latched_addr_next = latched_addr;
    read_mode_next    = read_mode;
    unique case (phase)
      PH_ST_A: begin
        if (!item.sda_in) begin
          fail_code_next = STAT_STUCK;
          bit_index_next = 4'd0;
          phase_next     = PH_UL_LOW;
        end else begin
          phase_next = PH_ST_B;
        end
      end
      PH_ST_B: begin
        if (item.sda_in) begin
          fail_code_next = STAT_STUCK;
          bit_index_next = 4'd0;
          phase_next     = PH_UL_LOW;
        end else begin
          shift_reg_next = dev_byte(cfg.device_code, latched_addr);
          stage_next     = STG_DEV_W;
          bit_index_next = 4'd0;
          phase_next     = PH_BIT_LOW;
        end
      end
      PH_LOAD: begin
        shift_reg_next  = item.wr_byte;
        bytes_left_next = bytes_dec;
        bit_index_next  = 4'd0;
        phase_next      = PH_BIT_HIGH;
      end
      PH_BIT_LOW: phase_next = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        shift_reg_next = {shift_reg[6:0], 1'b0};
        bit_index_next = bit_inc;
        phase_next     = (bit_inc >= 4'd8) ? PH_ACK_REL : PH_BIT_LOW;
      end
      PH_ACK_REL: phase_next = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        poll_count_next = 10'd0;
        phase_next      = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!item.sda_in) begin
          phase_next      = adv_phase;
          stage_next      = adv_stage;
          after_stop_next = adv_after;
          shift_reg_next  = adv_shift;
          bit_index_next  = adv_bit;
        end else if (poll_inc > {1'b0, cfg.ack_timeout_polls}) begin
          poll_count_next = 10'd0;
          if (stage == STG_DEV_W) begin
            fail_code_next  = STAT_NACK;
            after_stop_next = AFT_UNLOCK;
          end else begin
            after_stop_next = AFT_RESUME;
          end
          phase_next = PH_SP_A;
        end else begin
          poll_count_next = poll_inc[9:0];
        end
      end
      PH_RS_A: phase_next = PH_RS_B;
      PH_RS_B: phase_next = PH_RS_C;
      PH_RS_C: phase_next = PH_RS_D;
      PH_RS_D: begin
        shift_reg_next = dev_byte(cfg.device_code, latched_addr) | 8'h01;
        stage_next     = STG_DEV_R;
        bit_index_next = 4'd0;
        phase_next     = PH_BIT_LOW;
      end
      PH_RX_LOW:  phase_next = PH_RX_HIGH;
      PH_RX_HIGH: phase_next = PH_RX_SAMPLE;
      PH_RX_SAMPLE: begin
        shift_reg_next = rx_shift;
        bit_index_next = bit_inc;
        phase_next     = (bit_inc >= 4'd8) ? PH_MA_LOW : PH_RX_LOW;
      end
      PH_MA_LOW:  phase_next = PH_MA_HIGH;
      PH_MA_HIGH: phase_next = PH_MA_END;
      PH_MA_END: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec != '0) begin
          bit_index_next = 4'd0;
          shift_reg_next = 8'd0;
          phase_next     = PH_RX_LOW;
        end else begin
          after_stop_next = AFT_FINAL;
          phase_next      = PH_SP_A;
        end
      end
      PH_SP_A: phase_next = PH_SP_B;
      PH_SP_B: phase_next = PH_SP_C;
      PH_SP_C: begin
        if (after_stop == AFT_RESUME) begin
          phase_next      = adv_phase;
          stage_next      = adv_stage;
          after_stop_next = adv_after;
          shift_reg_next  = adv_shift;
          bit_index_next  = adv_bit;
        end else if (after_stop == AFT_UNLOCK) begin
          bit_index_next = 4'd0;
          phase_next     = PH_UL_LOW;
        end else if (after_stop == AFT_FAIL) begin
          phase_next = PH_IDLE;
        end else if (read_mode || cfg.write_settle_ticks == 16'd0) begin
          phase_next = PH_IDLE;
        end else begin
          wait_ticks_next = cfg.write_settle_ticks;
          phase_next      = PH_SETTLE;
        end
      end
      PH_UL_LOW: phase_next = PH_UL_HIGH;
      PH_UL_HIGH: begin
        bit_index_next = bit_inc;
        if (bit_inc >= 4'd9) begin
          if (fail_code == STAT_NACK) begin
            after_stop_next = AFT_FAIL;
            phase_next      = PH_SP_A;
          end else begin
            phase_next = PH_IDLE;
          end
        end else begin
          phase_next = PH_UL_LOW;
        end
      end
      PH_SETTLE: begin
        if (wait_ticks <= 16'd1) begin
          wait_ticks_next = 16'd0;
          phase_next      = PH_IDLE;
        end else begin
          wait_ticks_next = wait_ticks - 16'd1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.start_req) begin
          latched_addr_next = item.mem_addr;
          bytes_left_next   = COUNT_BITS'(item.byte_count);
          read_mode_next    = item.is_read;
          fail_code_next    = STAT_OK;
          phase_next        = PH_ST_A;
        end
      end
    endcase
  end

  // pin and result outputs
  always_comb begin
    scl  = 1'b1;
    sda  = 1'b1;
    rdv  = 1'b0;
    rdb  = 8'd0;
    done = 1'b0;
    stat = STAT_OK;
    unique case (phase)
      PH_ST_A: begin
        if (item.sda_in) sda = 1'b0;
      end
      PH_ST_B: begin
        if (!item.sda_in) begin
          scl = 1'b0;
          sda = 1'b0;
        end
      end
      PH_LOAD: begin
        scl = 1'b0;
        sda = item.wr_byte[7];
      end
      PH_BIT_LOW: begin
        scl = 1'b0;
        sda = shift_reg[7];
      end
      PH_BIT_HIGH: sda = shift_reg[7];
      PH_ACK_REL:  scl = 1'b0;
      PH_ACK_POLL: begin
        if (!item.sda_in) scl = 1'b0;
      end
      PH_RS_A: scl = 1'b0;
      PH_RS_C: sda = 1'b0;
      PH_RS_D: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_RX_LOW: scl = 1'b0;
      PH_RX_SAMPLE: begin
        if (bit_inc >= 4'd8) begin
          scl = 1'b0;
          rdv = 1'b1;
          rdb = rx_shift;
        end
      end
      PH_MA_LOW: begin
        scl = 1'b0;
        sda = last_byte;
      end
      PH_MA_HIGH: sda = last_byte;
      PH_MA_END: begin
        scl = 1'b0;
        sda = last_byte;
      end
      PH_SP_A: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_SP_B: sda = 1'b0;
      PH_SP_C: begin
        if (after_stop == AFT_FAIL) begin
          done = 1'b1;
          stat = STAT_NACK;
        end else if (after_stop == AFT_FINAL &&
                     (read_mode || cfg.write_settle_ticks == 16'd0)) begin
          done = 1'b1;
        end
      end
      PH_UL_LOW: scl = 1'b0;
      PH_UL_HIGH: begin
        if (bit_inc >= 4'd9 && fail_code != STAT_NACK) begin
          done = 1'b1;
          stat = STAT_STUCK;
        end
      end
      PH_SETTLE: begin
        if (wait_ticks <= 16'd1) done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res.scl_level = scl;
  assign res.sda_level = sda;
  assign res.want_byte = (phase_next == PH_LOAD);
  assign res.rd_byte   = rdb;
  assign res.rd_valid  = rdv;
  assign res.busy_res  = (phase_next != PH_IDLE);
  assign res.done_res  = done;
  assign res.status    = stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      stage        <= STG_DEV_W;
      after_stop   <= AFT_FINAL;
      fail_code    <= STAT_OK;
      shift_reg    <= 8'd0;
      bit_index    <= 4'd0;
      bytes_left   <= '0;
      wait_ticks   <= 16'd0;
      poll_count   <= 10'd0;
      latched_addr <= 11'd0;
      read_mode    <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      stage        <= stage_next;
      after_stop   <= after_stop_next;
      fail_code    <= fail_code_next;
      shift_reg    <= shift_reg_next;
      bit_index    <= bit_index_next;
      bytes_left   <= bytes_left_next;
      wait_ticks   <= wait_ticks_next;
      poll_count   <= poll_count_next;
      latched_addr <= latched_addr_next;
      read_mode    <= read_mode_next;
    end
  end

  `I2CM_ASSERT_NOW(a_done_not_busy, clk, rst, step && res.done_res, !res.busy_res, "done while busy")
  `I2CM_ASSERT_NOW(a_status_with_done, clk, rst, step && res.status != STAT_OK, res.done_res, "status without done")
  `I2CM_ASSERT_NOW(a_rd_only_read, clk, rst, step && res.rd_valid, read_mode, "read byte in write")
  `I2CM_ASSERT_NEXT(a_idle_holds, clk, rst, step && phase == PH_IDLE && !item.start_req, phase == PH_IDLE, "left idle without start")

endmodule

`default_nettype wire
